[rtl/tccw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

   // Default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Fixed field widths
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int READ_ROW_W = 5;
   localparam int READ_COL_W = 7;
   localparam int POS_W      = 11;
   localparam int CELL_W     = CHAR_W + ATTR_W;

   // Cell contents
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

   // Command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_PUT       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BACKSPACE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

   // Operation kinds handed from front to back
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] OP_PUT       = 3'd0;
   localparam logic [KIND_W-1:0] OP_NEWLINE   = 3'd1;
   localparam logic [KIND_W-1:0] OP_BACKSPACE = 3'd2;
   localparam logic [KIND_W-1:0] OP_CLEAR     = 3'd3;
   localparam logic [KIND_W-1:0] OP_READ      = 3'd4;
   localparam logic [KIND_W-1:0] OP_READ_MISS = 3'd5;

   // Operation queue depth
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [CHAR_W-1:0]     char_code;
      logic [ATTR_W-1:0]     attr;
      logic [READ_ROW_W-1:0] read_row;
      logic [READ_COL_W-1:0] read_col;
   } op_type;

endpackage

`default_nettype wire

[rtl/tccw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/tccw_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tccw_queue import tccw_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   input  wire logic   pop,
   output logic        empty,
   output op_type      head_op
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   op_type           q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = q_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

[rtl/tccw_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tccw_front import tccw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [CHAR_W-1:0]     req_char_code,
   input  wire logic [READ_ROW_W-1:0] req_read_row,
   input  wire logic [READ_COL_W-1:0] req_read_col,
   input  wire logic                  csr_wr_en,
   input  wire logic [ATTR_W-1:0]     csr_wr_data,
   input  wire logic                  queue_full,
   input  wire logic                  init_busy,
   output logic                       push,
   output op_type                     push_op
);

   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              read_hit;

   // Text attribute register
   always_comb begin
      attr_in = attr_ff;
      if (csr_wr_en) begin
         attr_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // No beats taken while the screen is being blanked after reset
   assign req_ready = !queue_full && !init_busy;
   assign push      = req_valid && req_ready;

   assign read_hit = (32'(req_read_row) < 32'(ROWS)) && (32'(req_read_col) < 32'(COLUMNS));

   // Classify the command; the attribute is captured with the beat
   always_comb begin
      push_op.char_code = req_char_code;
      push_op.attr      = attr_ff;
      push_op.read_row  = req_read_row;
      push_op.read_col  = req_read_col;
      unique case (req_cmd)
         CMD_PUT: begin
            if (req_char_code == CHAR_LF || req_char_code == CHAR_CR) begin
               push_op.kind = OP_NEWLINE;
            end else begin
               push_op.kind = OP_PUT;
            end
         end
         CMD_BACKSPACE: push_op.kind = OP_BACKSPACE;
         CMD_CLEAR:     push_op.kind = OP_CLEAR;
         CMD_READ:      push_op.kind = read_hit ? OP_READ : OP_READ_MISS;
         default:       push_op.kind = OP_READ_MISS;
      endcase
   end

endmodule

`default_nettype wire

[rtl/tccw_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tccw_back import tccw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire op_type            head_op,
   output logic                   pop,
   output logic                   init_busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [POS_W-1:0]       rsp_cursor_position,
   output logic [CHAR_W-1:0]      rsp_cell_char,
   output logic [ATTR_W-1:0]      rsp_cell_attr
);

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [2:0] S_SWEEP  = 3'd0;
   localparam logic [2:0] S_FETCH  = 3'd1;
   localparam logic [2:0] S_ADDR   = 3'd2;
   localparam logic [2:0] S_ACCESS = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0]        state_ff, state_in;
   op_type            op_ff, op_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ROW_W-1:0]  tgt_row_ff, tgt_row_in;
   logic [COL_W-1:0]  tgt_col_ff, tgt_col_in;
   logic              scroll_ff, scroll_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_left_ff, sweep_left_in;
   logic [ATTR_W-1:0] sweep_attr_ff, sweep_attr_in;
   logic              init_busy_ff, init_busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;

   logic              col_last;
   logic              row_last;
   logic [ROW_W-1:0]  lrow;
   logic [COL_W-1:0]  lcol;
   logic [ROW_W:0]    prow_sum;
   logic [ROW_W-1:0]  prow;
   logic [ADDR_W-1:0] access_addr;
   logic [ADDR_W-1:0] top_base;
   logic              rsp_free;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [CELL_W-1:0] mem_rd_data;

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   assign col_last = (cursor_col_ff == COL_W'(COLUMNS - 1));
   assign row_last = (cursor_row_ff == ROW_W'(ROWS - 1));

   // Logical to physical row: rows rotate by top_ff so a scroll moves no data
   assign prow_sum = (ROW_W+1)'(lrow) + (ROW_W+1)'(top_ff);
   assign prow     = (prow_sum >= (ROW_W+1)'(ROWS)) ?
                     ROW_W'(prow_sum - (ROW_W+1)'(ROWS)) : ROW_W'(prow_sum);

   assign access_addr = ADDR_W'(tgt_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(tgt_col_ff);
   assign top_base    = ADDR_W'(top_ff) * ADDR_W'(COLUMNS);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      top_in        = top_ff;
      tgt_row_in    = tgt_row_ff;
      tgt_col_in    = tgt_col_ff;
      scroll_in     = scroll_ff;
      pos_in        = pos_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_left_in = sweep_left_ff;
      sweep_attr_in = sweep_attr_ff;
      init_busy_in  = init_busy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      pop           = 1'b0;
      lrow          = cursor_row_ff;
      lcol          = cursor_col_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_addr      = access_addr;
      mem_wr_data   = {op_ff.attr, op_ff.char_code};

      unique case (state_ff)
         // Blank a run of cells, one per cycle
         S_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_addr    = sweep_addr_ff;
            mem_wr_data = {sweep_attr_ff, BLANK_CHAR};
            if (sweep_left_ff == '0) begin
               init_busy_in = 1'b0;
               state_in     = S_FETCH;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
               sweep_left_in = sweep_left_ff - 1'b1;
            end
         end

         S_FETCH: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               op_in    = head_op;
               state_in = S_ADDR;
            end
         end

         // Cursor update and target cell
         S_ADDR: begin
            scroll_in = 1'b0;
            case (op_ff.kind)
               OP_PUT: begin
                  if (col_last) begin
                     cursor_col_in = '0;
                     if (row_last) begin
                        scroll_in = 1'b1;
                     end else begin
                        cursor_row_in = cursor_row_ff + 1'b1;
                     end
                  end else begin
                     cursor_col_in = cursor_col_ff + 1'b1;
                  end
               end
               OP_NEWLINE: begin
                  cursor_col_in = '0;
                  if (row_last) begin
                     scroll_in = 1'b1;
                  end else begin
                     cursor_row_in = cursor_row_ff + 1'b1;
                  end
               end
               OP_BACKSPACE: begin
                  // top-left corner keeps the cursor
                  if (cursor_col_ff != '0) begin
                     cursor_col_in = cursor_col_ff - 1'b1;
                  end else if (cursor_row_ff != '0) begin
                     cursor_col_in = COL_W'(COLUMNS - 1);
                     cursor_row_in = cursor_row_ff - 1'b1;
                  end
                  lrow = cursor_row_in;
                  lcol = cursor_col_in;
               end
               OP_CLEAR: begin
                  cursor_col_in = '0;
                  cursor_row_in = '0;
               end
               OP_READ: begin
                  lrow = ROW_W'(op_ff.read_row);
                  lcol = COL_W'(op_ff.read_col);
               end
               default: ;
            endcase
            tgt_row_in = prow;
            tgt_col_in = lcol;
            state_in   = S_ACCESS;
         end

         S_ACCESS: begin
            mem_wr_en = (op_ff.kind == OP_PUT) || (op_ff.kind == OP_BACKSPACE);
            mem_rd_en = (op_ff.kind == OP_READ);
            if (op_ff.kind == OP_BACKSPACE) begin
               mem_wr_data = {op_ff.attr, BLANK_CHAR};
            end
            pos_in   = ADDR_W'(cursor_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col_ff);
            state_in = S_RESULT;
         end

         // Load the response, then start a clear or scroll sweep if due
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(pos_ff);
               if (op_ff.kind == OP_READ) begin
                  rsp_char_in = mem_rd_data[CHAR_W-1:0];
                  rsp_attr_in = mem_rd_data[CELL_W-1:CHAR_W];
               end else begin
                  rsp_char_in = '0;
                  rsp_attr_in = '0;
               end
               sweep_attr_in = op_ff.attr;
               if (op_ff.kind == OP_CLEAR) begin
                  top_in        = '0;
                  sweep_addr_in = '0;
                  sweep_left_in = ADDR_W'(CELLS - 1);
                  state_in      = S_SWEEP;
               end else if (scroll_ff) begin
                  // old top row becomes the new bottom row
                  top_in        = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                  sweep_addr_in = top_base;
                  sweep_left_in = ADDR_W'(COLUMNS - 1);
                  state_in      = S_SWEEP;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end

         default: state_in = S_FETCH;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         top_ff        <= '0;
         scroll_ff     <= 1'b0;
         sweep_addr_ff <= '0;
         sweep_left_ff <= ADDR_W'(CELLS - 1);
         sweep_attr_ff <= RESET_ATTR;
         init_busy_ff  <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         top_ff        <= top_in;
         scroll_ff     <= scroll_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_left_ff <= sweep_left_in;
         sweep_attr_ff <= sweep_attr_in;
         init_busy_ff  <= init_busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tgt_row_ff  <= tgt_row_in;
      tgt_col_ff  <= tgt_col_in;
      pos_ff      <= pos_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   assign init_busy           = init_busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_char       = rsp_char_ff;
   assign rsp_cell_attr       = rsp_attr_ff;

endmodule

`default_nettype wire

[rtl/text_console_cell_writer_unit.sv]
// Text console with a ROWS x COLUMNS screen of character cells and a cursor.
// Request channel (req_valid/req_ready): one beat per command: put character,
// backspace, clear screen or read cell. Response channel (rsp_valid/rsp_ready):
// exactly one beat per command, in order, with the cursor position after the
// command and, for a read, the cell's character and attribute (zero off screen).
// csr_wr_en/csr_wr_data set the attribute used for written and blanked cells;
// it is captured with each request beat.
// A front stage classifies requests into a four-entry queue; a back sequencer
// owns the cursor and the single-port screen RAM. Each command passes through
// the sequencer's fetch, address, RAM access and response states, and the
// next command is fetched only once the response is loaded and any sweep is done.
// A scroll adds a sweep that blanks the new bottom row (rows rotate by a
// top-row pointer, no data moves); a clear adds a sweep of all COLUMNS*ROWS cells.
// After reset the sequencer blanks all COLUMNS*ROWS cells with attribute 7;
// req_ready stays low until it is done.
// When the receiver stalls, the response is held in the output register,
// the sequencer waits, and the queue absorbs up to four more requests.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cell_writer_unit import tccw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [CHAR_W-1:0]     req_char_code,
   input  wire logic [READ_ROW_W-1:0] req_read_row,
   input  wire logic [READ_COL_W-1:0] req_read_col,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [POS_W-1:0]           rsp_cursor_position,
   output logic [CHAR_W-1:0]          rsp_cell_char,
   output logic [ATTR_W-1:0]          rsp_cell_attr,
   input  wire logic                  csr_wr_en,
   input  wire logic [ATTR_W-1:0]     csr_wr_data
);

   logic   push;
   op_type push_op;
   logic   queue_full;
   logic   queue_empty;
   logic   pop;
   op_type head_op;
   logic   init_busy;

   tccw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .queue_full    (queue_full),
      .init_busy     (init_busy),
      .push          (push),
      .push_op       (push_op)
   );

   tccw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .empty   (queue_empty),
      .head_op (head_op)
   );

   tccw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_empty         (queue_empty),
      .head_op             (head_op),
      .pop                 (pop),
      .init_busy           (init_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_attr       (rsp_cell_attr)
   );

endmodule

`default_nettype wire
